// ===== hw/rtl/pfh_pkg.sv =====
// Shared constants, payload types and state codes for the polygon footprint height block.
// No dependencies; every other file in hw/rtl except pfh_ram imports this package.
package pfh_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   localparam int COORD_W   = 32;
   localparam int MUL_W     = COORD_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DET_W     = PROD_W + 1;
   localparam int ACC_W     = 80;
   localparam int FRAC_W    = 16;
   localparam int DIV_NUM_W = 84;
   localparam int DIV_DEN_W = DET_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int WT_W      = 43;
   localparam int WT_HI_W   = WT_W - COORD_W;
   localparam int STEP_W    = 3;

   localparam int WEIGHT_LIMIT_LOG2 = 40;
   localparam logic [DIV_NUM_W-1:0] WEIGHT_LIMIT = DIV_NUM_W'(1) << WEIGHT_LIMIT_LOG2;
   localparam logic [ACC_W-1:0] DET_MIN = ACC_W'(43);
   localparam logic signed [WT_W-1:0] MIN_WEIGHT = WT_W'(-7);
   localparam logic signed [WT_W-1:0] WEIGHT_ONE = WT_W'(65536);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_FAN  = 2'd1;
   localparam logic [1:0] SRC_MEAN = 2'd2;

   localparam logic [STEP_W-1:0] PAIR_LAST_STEP = STEP_W'(1);
   localparam logic [STEP_W-1:0] HGT_LAST_STEP  = STEP_W'(5);

   typedef struct packed {
      logic [1:0]                operation;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic                      inside_res;
      logic [1:0]                height_source;
      logic signed [COORD_W-1:0] base_height;
      logic                      store_full;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic       hi;
   } mac_ctl_type;

   typedef enum logic [2:0] {PROG_CROSS, PROG_DET, PROG_UNUM, PROG_VNUM, PROG_HGT} mul_prog_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_C_LDB, ST_C_LDA, ST_C_TEST, ST_C_DEC, ST_C_NEXT,
      ST_MUL, ST_MWAIT,
      ST_F_LD0, ST_F_LD1, ST_F_LDC, ST_F_DETCHK, ST_F_UDIV, ST_F_UWAIT,
      ST_F_VDIV, ST_F_VWAIT, ST_F_WCHK, ST_F_HFIN, ST_F_NEXT,
      ST_M_RD, ST_M_ACC, ST_M_SUMW, ST_M_DIV, ST_M_WAIT
   } state_type;

   function automatic logic signed [MUL_W-1:0] sub33(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      logic signed [MUL_W-1:0] ea;
      logic signed [MUL_W-1:0] eb;
      ea = {a[COORD_W-1], a};
      eb = {b[COORD_W-1], b};
      return ea - eb;
   endfunction

endpackage

// ===== hw/rtl/polygon_footprint_height.sv =====
// Polygon footprint height: vertex store, crossing test and fan/mean height sequencer.
// Depends on pfh_pkg, pfh_ram, pfh_div and pfh_mac.
//
// Usage: drive req_data and raise start; the item transfers at a rising edge where start
// is high and busy is low. Every item yields one result: rsp_valid is high for exactly
// one cycle with rsp_data, and the receiver must take it then (it cannot stall).
// Clear, append, unused codes and queries on fewer than three vertices answer in the
// cycle after the transfer and leave busy low, so these may follow every cycle.
// A query walks the edge ring through one shared 33x33 multiplier, with extra multiplies
// for each straddling edge, then the fan triangles: each non-degenerate one takes two serial
// divisions in one shared divider plus multiplies and checks; a degenerate triangle is
// dropped after its determinant check, before any division.
// Worst case at 64 vertices has every edge straddling, no usable triangle and the mean
// fallback; a hit on an early triangle ends the query sooner. The mean fallback sums the
// vertex heights one vertex at a time and then does one more division.
// busy stays high for the whole query and rsp_valid is high in the first cycle busy is low.
// Reset empties the vertex store (count zero) and returns the sequencer to idle;
// store contents are not cleared and are never read past the count.
module polygon_footprint_height (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pfh_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output pfh_pkg::rsp_type rsp_data
);
   import pfh_pkg::*;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   mul_prog_type              prog_ff, prog_in;
   logic [STEP_W-1:0]         mstep_ff, mstep_in;
   logic signed [COORD_W-1:0] px_ff, px_in, pz_ff, pz_in;
   vertex_type                r0_ff, r0_in, rb_ff, rb_in, rc_ff, rc_in;
   logic                      inside_ff, inside_in;
   logic signed [DET_W-1:0]   det_ff, det_in;
   logic signed [WT_W-1:0]    u_ff, u_in, v_ff, v_in, w_ff, w_in;
   logic                      neg_ff, neg_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr, ram_raddr;
   vertex_type             ram_wdata, rd_vtx;
   logic signed [MUL_W-1:0] mac_a, mac_b;
   mac_ctl_type            mac_ctl;
   logic signed [ACC_W-1:0] acc;
   logic                   div_start, div_busy, div_done, div_rem_nz;
   logic [DIV_NUM_W-1:0]   div_num, div_quot;
   logic [DIV_DEN_W-1:0]   div_den;

   logic                    accept, last_idx, mul_last, straddle, toggle;
   logic                    det_small, weight_ok;
   logic [CNT_W-1:0]        total_m1, idx_p1;
   logic [ACC_W-1:0]        acc_mag, mean_mag;
   logic signed [ACC_W-1:0] mean_num, hsum, hsh;
   logic [DET_W-1:0]        det_mag;
   logic [WT_W-1:0]         weight_mag;
   logic signed [WT_W-1:0]  weight_q, w_calc;
   logic [DIV_NUM_W-1:0]    mean_q;
   logic                    h_ovf;
   logic signed [COORD_W-1:0] fan_h;
   logic signed [MUL_W-1:0] d0x, d0z, d1x, d1z, v2x, v2z;
   rsp_type                 rsp_zero;

   pfh_ram #(.WIDTH($bits(vertex_type)), .DEPTH(MAX_VERTICES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd_vtx)
   );

   pfh_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   pfh_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .busy   (div_busy),
      .done   (div_done),
      .quot   (div_quot),
      .rem_nz (div_rem_nz)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign total_m1 = total_ff - 1'b1;
   assign idx_p1   = idx_ff + 1'b1;
   assign last_idx = (idx_ff == total_m1);
   assign mul_last = (prog_ff == PROG_HGT) ? (mstep_ff == HGT_LAST_STEP)
                                           : (mstep_ff == PAIR_LAST_STEP);
   assign rsp_zero = '{inside_res: 1'b0, height_source: SRC_NONE, base_height: '0,
                       store_full: 1'b0};

   // crossing: rc is vertex i, rb is the vertex before it on the ring
   assign straddle = (rc_ff.z > pz_ff) != (rb_ff.z > pz_ff);
   assign toggle   = (rb_ff.z > pz_ff) ? acc[ACC_W-1] : (!acc[ACC_W-1] && acc != '0);

   // fan triangle edges from vertex 0
   assign d0x = sub33(rb_ff.x, r0_ff.x);
   assign d0z = sub33(rb_ff.z, r0_ff.z);
   assign d1x = sub33(rc_ff.x, r0_ff.x);
   assign d1z = sub33(rc_ff.z, r0_ff.z);
   assign v2x = sub33(px_ff, r0_ff.x);
   assign v2z = sub33(pz_ff, r0_ff.z);

   assign acc_mag    = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
   assign det_small  = (acc_mag < DET_MIN);
   assign det_mag    = det_ff[DET_W-1] ? (~det_ff + 1'b1) : det_ff;
   assign weight_mag = (div_quot > WEIGHT_LIMIT) ? WEIGHT_LIMIT[WT_W-1:0] : div_quot[WT_W-1:0];
   assign weight_q   = neg_ff ? (~weight_mag + 1'b1) : weight_mag;
   assign w_calc     = WEIGHT_ONE - u_ff - v_ff;
   assign weight_ok  = (u_ff >= MIN_WEIGHT) && (v_ff >= MIN_WEIGHT) && (w_calc >= MIN_WEIGHT);

   assign mean_num = {acc[ACC_W-2:0], 1'b0} + {{(ACC_W-CNT_W){1'b0}}, total_ff};
   assign mean_mag = mean_num[ACC_W-1] ? (~mean_num + 1'b1) : mean_num;
   assign mean_q   = !neg_ff ? div_quot : (div_rem_nz ? ~div_quot : (~div_quot + 1'b1));

   assign hsum  = acc + ROUND_HALF;
   assign hsh   = hsum >>> FRAC_W;
   assign h_ovf = (hsh[ACC_W-1:COORD_W-1] != '0) && (hsh[ACC_W-1:COORD_W-1] != '1);
   assign fan_h = h_ovf ? (hsh[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}})
                        : hsh[COORD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_QUERY && total_ff >= CNT_W'(3)) begin
               state_in = ST_C_LDB;
            end
         end
         ST_C_LDB:  state_in = ST_C_LDA;
         ST_C_LDA:  state_in = ST_C_TEST;
         ST_C_TEST: state_in = straddle ? ST_MUL : ST_C_NEXT;
         ST_C_DEC:  state_in = ST_C_NEXT;
         ST_C_NEXT: begin
            if (!last_idx) begin
               state_in = ST_C_LDA;
            end else if (inside_ff) begin
               state_in = ST_F_LD0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (mul_last) begin
               state_in = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            case (prog_ff)
               PROG_CROSS: state_in = ST_C_DEC;
               PROG_DET:   state_in = ST_F_DETCHK;
               PROG_UNUM:  state_in = ST_F_UDIV;
               PROG_VNUM:  state_in = ST_F_VDIV;
               default:    state_in = ST_F_HFIN;
            endcase
         end
         ST_F_LD0:    state_in = ST_F_LD1;
         ST_F_LD1:    state_in = ST_F_LDC;
         ST_F_LDC:    state_in = ST_MUL;
         ST_F_DETCHK: state_in = det_small ? ST_F_NEXT : ST_MUL;
         ST_F_UDIV:   state_in = ST_F_UWAIT;
         ST_F_UWAIT: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_F_VDIV:   state_in = ST_F_VWAIT;
         ST_F_VWAIT: begin
            if (div_done) begin
               state_in = ST_F_WCHK;
            end
         end
         ST_F_WCHK:   state_in = weight_ok ? ST_MUL : ST_F_NEXT;
         ST_F_HFIN:   state_in = ST_IDLE;
         ST_F_NEXT:   state_in = last_idx ? ST_M_RD : ST_F_LDC;
         ST_M_RD:     state_in = ST_M_ACC;
         ST_M_ACC: begin
            if (last_idx) begin
               state_in = ST_M_SUMW;
            end
         end
         ST_M_SUMW:   state_in = ST_M_DIV;
         ST_M_DIV:    state_in = ST_M_WAIT;
         ST_M_WAIT: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      total_in     = total_ff;
      idx_in       = idx_ff;
      prog_in      = prog_ff;
      mstep_in     = mstep_ff;
      px_in        = px_ff;
      pz_in        = pz_ff;
      r0_in        = r0_ff;
      rb_in        = rb_ff;
      rc_in        = rc_ff;
      inside_in    = inside_ff;
      det_in       = det_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = total_ff[IDX_W-1:0];
      ram_wdata    = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
      ram_raddr    = idx_p1[IDX_W-1:0];
      mac_a        = '0;
      mac_b        = '0;
      mac_ctl      = '{op: MAC_NONE, hi: 1'b0};
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = total_m1[IDX_W-1:0];
            if (accept) begin
               rsp_in       = rsp_zero;
               rsp_valid_in = 1'b1;
               px_in        = req_data.coord_x;
               pz_in        = req_data.coord_z;
               inside_in    = 1'b0;
               case (req_data.operation)
                  OP_CLEAR: total_in = '0;
                  OP_APPEND: begin
                     if (total_ff >= CNT_W'(MAX_VERTICES)) begin
                        rsp_in.store_full = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     // hold the result back while the query walks the polygon
                     if (total_ff >= CNT_W'(3)) begin
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_C_LDB: begin
            rb_in     = rd_vtx;
            idx_in    = '0;
            ram_raddr = '0;
         end
         ST_C_LDA: rc_in = rd_vtx;
         ST_C_TEST: begin
            prog_in  = PROG_CROSS;
            mstep_in = '0;
         end
         ST_C_DEC: begin
            if (toggle) begin
               inside_in = !inside_ff;
            end
         end
         ST_C_NEXT: begin
            rb_in = rc_ff;
            if (!last_idx) begin
               idx_in = idx_p1;
            end else if (inside_ff) begin
               ram_raddr = '0;
            end else begin
               rsp_in       = rsp_zero;
               rsp_valid_in = 1'b1;
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 1'b1;
            mac_ctl  = '{op: (mstep_ff == '0) ? MAC_LOAD : MAC_SUB, hi: 1'b0};
            case (prog_ff)
               PROG_CROSS: begin
                  mac_a = (mstep_ff == '0) ? sub33(px_ff, rc_ff.x) : sub33(rb_ff.x, rc_ff.x);
                  mac_b = (mstep_ff == '0) ? sub33(rb_ff.z, rc_ff.z) : sub33(pz_ff, rc_ff.z);
               end
               PROG_DET: begin
                  mac_a = (mstep_ff == '0) ? d0x : d1x;
                  mac_b = (mstep_ff == '0) ? d1z : d0z;
               end
               PROG_UNUM: begin
                  mac_a = (mstep_ff == '0) ? v2x : d1x;
                  mac_b = (mstep_ff == '0) ? d1z : v2z;
               end
               PROG_VNUM: begin
                  mac_a = (mstep_ff == '0) ? d0x : v2x;
                  mac_b = (mstep_ff == '0) ? v2z : d0z;
               end
               default: begin
                  // weight split into an unsigned low word and a signed high part
                  case (mstep_ff[STEP_W-1:1])
                     2'd0:    mac_a = mstep_ff[0] ? {{(MUL_W-WT_HI_W){w_ff[WT_W-1]}},
                                                     w_ff[WT_W-1:COORD_W]}
                                                  : {1'b0, w_ff[COORD_W-1:0]};
                     2'd1:    mac_a = mstep_ff[0] ? {{(MUL_W-WT_HI_W){u_ff[WT_W-1]}},
                                                     u_ff[WT_W-1:COORD_W]}
                                                  : {1'b0, u_ff[COORD_W-1:0]};
                     default: mac_a = mstep_ff[0] ? {{(MUL_W-WT_HI_W){v_ff[WT_W-1]}},
                                                     v_ff[WT_W-1:COORD_W]}
                                                  : {1'b0, v_ff[COORD_W-1:0]};
                  endcase
                  case (mstep_ff[STEP_W-1:1])
                     2'd0:    mac_b = {r0_ff.y[COORD_W-1], r0_ff.y};
                     2'd1:    mac_b = {rb_ff.y[COORD_W-1], rb_ff.y};
                     default: mac_b = {rc_ff.y[COORD_W-1], rc_ff.y};
                  endcase
                  mac_ctl = '{op: (mstep_ff == '0) ? MAC_LOAD : MAC_ADD, hi: mstep_ff[0]};
               end
            endcase
         end
         ST_F_LD0: begin
            r0_in     = rd_vtx;
            ram_raddr = IDX_W'(1);
         end
         ST_F_LD1: begin
            rb_in     = rd_vtx;
            idx_in    = CNT_W'(2);
            ram_raddr = IDX_W'(2);
         end
         ST_F_LDC: begin
            rc_in    = rd_vtx;
            prog_in  = PROG_DET;
            mstep_in = '0;
         end
         ST_F_DETCHK: begin
            det_in   = acc[DET_W-1:0];
            prog_in  = PROG_UNUM;
            mstep_in = '0;
         end
         ST_F_UDIV, ST_F_VDIV: begin
            div_start = 1'b1;
            div_num   = {acc_mag[DIV_NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            div_den   = det_mag;
            neg_in    = acc[ACC_W-1] ^ det_ff[DET_W-1];
         end
         ST_F_UWAIT: begin
            if (div_done) begin
               u_in     = weight_q;
               prog_in  = PROG_VNUM;
               mstep_in = '0;
            end
         end
         ST_F_VWAIT: begin
            if (div_done) begin
               v_in = weight_q;
            end
         end
         ST_F_WCHK: begin
            w_in     = w_calc;
            prog_in  = PROG_HGT;
            mstep_in = '0;
         end
         ST_F_HFIN: begin
            rsp_in       = '{inside_res: 1'b1, height_source: SRC_FAN, base_height: fan_h,
                             store_full: 1'b0};
            rsp_valid_in = 1'b1;
         end
         ST_F_NEXT: begin
            rb_in = rc_ff;
            if (!last_idx) begin
               idx_in = idx_p1;
            end
         end
         ST_M_RD: begin
            idx_in    = '0;
            ram_raddr = '0;
         end
         ST_M_ACC: begin
            mac_a   = {rd_vtx.y[COORD_W-1], rd_vtx.y};
            mac_b   = MUL_W'(1);
            mac_ctl = '{op: (idx_ff == '0) ? MAC_LOAD : MAC_ADD, hi: 1'b0};
            if (!last_idx) begin
               idx_in = idx_p1;
            end
         end
         ST_M_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(mean_mag);
            div_den   = DIV_DEN_W'({total_ff, 1'b0});
            neg_in    = mean_num[ACC_W-1];
         end
         ST_M_WAIT: begin
            if (div_done) begin
               rsp_in       = '{inside_res: 1'b1, height_source: SRC_MEAN,
                                base_height: mean_q[COORD_W-1:0], store_full: 1'b0};
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      prog_ff   <= prog_in;
      mstep_ff  <= mstep_in;
      px_ff     <= px_in;
      pz_ff     <= pz_in;
      r0_ff     <= r0_in;
      rb_ff     <= rb_in;
      rc_ff     <= rc_in;
      inside_ff <= inside_in;
      det_ff    <= det_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count above capacity");

   a_src_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.height_source != SRC_NONE |-> rsp_ff.inside_res)
      else $error("height source without inside flag");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.store_full |-> !rsp_ff.inside_res && $past(total_ff) ==
      CNT_W'(MAX_VERTICES))
      else $error("store_full without a full store");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == OP_CLEAR |=> total_ff == '0 && rsp_valid_ff)
      else $error("clear did not empty the store");

endmodule

// ===== hw/rtl/pfh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module pfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pfh_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on pfh_pkg for operand widths.
module pfh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pfh_pkg::DIV_NUM_W-1:0] num,
   input  logic [pfh_pkg::DIV_DEN_W-1:0] den,
   output logic                          busy,
   output logic                          done,
   output logic [pfh_pkg::DIV_NUM_W-1:0] quot,
   output logic                          rem_nz
);
   import pfh_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] nq_ff, nq_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] diff;
   logic                 qbit;

   assign rem_sh = {rem_ff, nq_ff[DIV_NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign qbit   = ~diff[DIV_DEN_W+1];

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_NUM_W);
         nq_in  = num;
         rem_in = '0;
         den_in = den;
      end else if (cnt_ff != '0) begin
         // shift one numerator bit in, subtract when it fits
         nq_in   = {nq_ff[DIV_NUM_W-2:0], qbit};
         rem_in  = qbit ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy   = (cnt_ff != '0);
   assign done   = done_ff;
   assign quot   = nq_ff;
   assign rem_nz = (rem_ff != '0);

endmodule

// ===== hw/rtl/pfh_mac.sv =====
// Shared signed multiplier with registered product and an accumulator behind it.
// Depends on pfh_pkg for widths and the accumulate control struct.
module pfh_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [pfh_pkg::MUL_W-1:0] op_a,
   input  logic signed [pfh_pkg::MUL_W-1:0] op_b,
   input  pfh_pkg::mac_ctl_type             ctl,
   output logic signed [pfh_pkg::ACC_W-1:0] acc
);
   import pfh_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   mac_ctl_type              ctl_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  ext;
   logic signed [ACC_W-1:0]  term;

   assign ext  = ACC_W'(prod_ff);
   assign term = ctl_ff.hi ? (ext <<< COORD_W) : ext;

   always_comb begin
      case (ctl_ff.op)
         MAC_LOAD: acc_in = term;
         MAC_ADD:  acc_in = acc_ff + term;
         MAC_SUB:  acc_in = acc_ff - term;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '{op: MAC_NONE, hi: 1'b0};
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
